@@ rtl/tdfe_pkg.sv @@
// ----------------------------------------------------------------------------
// tdfe_pkg
// Types, codes and tag helpers shared by the delimited frame extractor.
// ----------------------------------------------------------------------------
package tdfe_pkg;

  localparam int MAX_TAG  = 16;
  localparam int TAG_IDX_W = $clog2(MAX_TAG);
  localparam int TAG_LEN_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // reset values of the tag registers ("<customcmd>" / "</customcmd>")
  localparam logic [63:0] START_LOW_RST  = 64'd7164505128160289596;
  localparam logic [63:0] START_HIGH_RST = 64'd4088941;
  localparam logic [TAG_LEN_W-1:0] START_LEN_RST = 5'd11;
  localparam logic [63:0] END_LOW_RST    = 64'd7885649511788523324;
  localparam logic [63:0] END_HIGH_RST   = 64'd1046768995;
  localparam logic [TAG_LEN_W-1:0] END_LEN_RST = 5'd12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LEN    = 3'd5;

  // request function codes
  localparam logic FUNC_BYTE  = 1'b0;
  localparam logic FUNC_RESET = 1'b1;

  // result status codes
  localparam logic [2:0] ST_NO_START  = 3'd0;
  localparam logic [2:0] ST_START     = 3'd1;
  localparam logic [2:0] ST_IN_BODY   = 3'd2;
  localparam logic [2:0] ST_END       = 3'd3;
  localparam logic [2:0] ST_HIST      = 3'd4;
  localparam logic [2:0] ST_COMPLETE  = 3'd5;
  localparam logic [2:0] ST_RESET     = 3'd6;

  // "<hist>" watcher
  localparam logic [2:0] HIST_LAST = 3'd5;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_EMIT
  } seq_t;

  function automatic logic [7:0] tag_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [TAG_IDX_W-1:0] idx);
    logic [127:0] tag;
    tag = {hi, lo};
    return tag[8*idx +: 8];
  endfunction

  function automatic logic [TAG_LEN_W-1:0] eff_len(input logic [TAG_LEN_W-1:0] len);
    if (len == '0) begin
      return TAG_LEN_W'(1);
    end else if (len > TAG_LEN_W'(MAX_TAG)) begin
      return TAG_LEN_W'(MAX_TAG);
    end
    return len;
  endfunction

  function automatic logic [7:0] hist_char(input logic [2:0] p);
    logic [7:0] c;
    case (p)
      3'd0:    c = 8'h3C; // <
      3'd1:    c = 8'h68; // h
      3'd2:    c = 8'h69; // i
      3'd3:    c = 8'h73; // s
      3'd4:    c = 8'h74; // t
      default: c = 8'h3E; // >
    endcase
    return c;
  endfunction

endpackage

@@ rtl/tdfe_in_if.sv @@
// ----------------------------------------------------------------------------
// tdfe_in_if
// Request channel: one received byte or a parser reset per request.
// ----------------------------------------------------------------------------
interface tdfe_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

@@ rtl/tdfe_out_if.sv @@
// ----------------------------------------------------------------------------
// tdfe_out_if
// Result channel: status and an optional payload byte per result.
// ----------------------------------------------------------------------------
interface tdfe_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       last;

  modport source (output valid, status, payload_byte, payload_valid, last, input ready);
  modport sink   (input valid, status, payload_byte, payload_valid, last, output ready);
endinterface

@@ rtl/tdfe_cfg_if.sv @@
// ----------------------------------------------------------------------------
// tdfe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tdfe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tdfe_pkg::CFG_IDX_W-1:0]   index;
  logic [tdfe_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/tag_delimited_frame_extractor.sv @@
// ----------------------------------------------------------------------------
// tag_delimited_frame_extractor
// Hunts for a start tag, streams the frame body, stops at the end tag.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one request (a byte, or a reset to hunt phase when
// func is 1); out_ch gives one or more results per request, the final one
// flagged by last; cfg writes the tag registers and is always ready. Write
// cfg only while no request is in flight.
// Sequence: a request is latched when accepted and evaluated in the next
// cycle, in S_EVAL; a single result is loaded into the output register at
// the end of S_EVAL once the output is free. A body mismatch after n matched
// end-tag bytes flushes n+1 payload bytes: the shared tag-byte mux first
// walks them through the "<hist>" watcher (S_SCAN), then replays them to the
// output (S_EMIT, which holds while the output is not free). in_ch.ready is
// high only when the sequencer is idle.
// A request is latched even while a result waits in the output register;
// while out_ch.ready is low the sequencer holds before loading the next one.
// Reset (rst, synchronous) returns tag registers to "<customcmd>" and
// "</customcmd>", the parser to hunt phase, and drops any pending result.
module tag_delimited_frame_extractor (
  input logic clk,
  input logic rst,
  tdfe_in_if.sink    in_ch,
  tdfe_out_if.source out_ch,
  tdfe_cfg_if.sink   cfg
);
  import tdfe_pkg::*;

  // configuration
  logic [63:0]          start_low, start_high, end_low, end_high;
  logic [TAG_LEN_W-1:0] start_len, end_len;

  // parser state
  seq_t                 state, state_next;
  phase_t               phase;
  logic [TAG_LEN_W-1:0] match_count;
  logic [2:0]           hist_prog;

  // latched request and flush control
  logic                 func_q;
  logic [7:0]           byte_q;
  logic [TAG_IDX_W-1:0] idx, cnt;
  logic                 hit;

  // output register
  logic       o_valid;
  logic [2:0] o_status;
  logic [7:0] o_byte;
  logic       o_pvalid;
  logic       o_last;

  // shared tag byte select and compare
  logic                 use_start;
  logic [TAG_LEN_W-1:0] len_sel;
  logic [TAG_IDX_W-1:0] mc_norm, tag_idx;
  logic [TAG_LEN_W-1:0] mc_inc;
  logic [7:0]           tag_ch, cur_char;
  logic                 cmp_hit, idx_end;

  // "<hist>" watcher
  logic [2:0] hp, hp_next;
  logic       hist_eq, hist_found;

  logic out_free, flush_start, load_single, load_emit;

  assign use_start = (phase == PH_HUNT);
  assign len_sel   = eff_len(use_start ? start_len : end_len);
  assign mc_norm   = (match_count >= len_sel) ? '0 : match_count[TAG_IDX_W-1:0];
  assign mc_inc    = {1'b0, mc_norm} + TAG_LEN_W'(1);
  assign tag_idx   = (state == S_EVAL) ? mc_norm : idx;
  assign tag_ch    = (state == S_EVAL && use_start) ? tag_byte(start_low, start_high, tag_idx)
                                                    : tag_byte(end_low, end_high, tag_idx);
  assign idx_end   = (idx == cnt);
  assign cur_char  = (state == S_EVAL || idx_end) ? byte_q : tag_ch;
  assign cmp_hit   = (byte_q == tag_ch);

  assign hp         = (hist_prog > HIST_LAST) ? 3'd0 : hist_prog;
  assign hist_eq    = (cur_char == hist_char(hp));
  assign hist_found = hist_eq && (hp == HIST_LAST);
  always_comb begin
    if (hist_eq) begin
      hp_next = hist_found ? 3'd0 : hp + 3'd1;
    end else begin
      hp_next = (cur_char == hist_char(3'd0)) ? 3'd1 : 3'd0;
    end
  end

  assign out_free    = !o_valid || out_ch.ready;
  assign flush_start = (func_q == FUNC_BYTE) && (phase == PH_BODY) && !cmp_hit;
  assign load_single = (state == S_EVAL) && !flush_start && out_free;
  assign load_emit   = (state == S_EMIT) && out_free;

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (flush_start) state_next = S_SCAN;
        else if (out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (idx_end) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free && idx_end) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and port outputs
  always_comb begin
    in_ch.ready          = (state == S_IDLE);
    cfg.ready            = 1'b1;
    out_ch.valid         = o_valid;
    out_ch.status        = o_status;
    out_ch.payload_byte  = o_byte;
    out_ch.payload_valid = o_pvalid;
    out_ch.last          = o_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_low  <= START_LOW_RST;
      start_high <= START_HIGH_RST;
      start_len  <= START_LEN_RST;
      end_low    <= END_LOW_RST;
      end_high   <= END_HIGH_RST;
      end_len    <= END_LEN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_START_LOW:  start_low  <= cfg.data;
        CFG_START_HIGH: start_high <= cfg.data;
        CFG_START_LEN:  start_len  <= cfg.data[TAG_LEN_W-1:0];
        CFG_END_LOW:    end_low    <= cfg.data;
        CFG_END_HIGH:   end_high   <= cfg.data;
        CFG_END_LEN:    end_len    <= cfg.data[TAG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_q <= in_ch.func;
      byte_q <= in_ch.data_byte;
    end
  end

  // parser state and flush walk
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      match_count <= '0;
      hist_prog   <= '0;
      idx         <= '0;
      cnt         <= '0;
      hit         <= 1'b0;
    end else begin
      unique case (state)
        S_EVAL: begin
          if (func_q == FUNC_RESET) begin
            if (out_free) begin
              phase       <= PH_HUNT;
              match_count <= '0;
              hist_prog   <= '0;
            end
          end else if (phase == PH_HUNT || (phase == PH_BODY && cmp_hit)) begin
            if (out_free) begin
              if (!cmp_hit) begin
                match_count <= '0;
              end else if (mc_inc == len_sel) begin
                match_count <= '0;
                phase       <= use_start ? PH_BODY : PH_DONE;
              end else begin
                match_count <= mc_inc;
              end
            end
          end else if (flush_start) begin
            cnt         <= mc_norm;
            idx         <= '0;
            hit         <= 1'b0;
            match_count <= '0;
          end
        end
        S_SCAN: begin
          // feed the watcher until the first hit, then freeze it at zero
          if (!hit) begin
            hist_prog <= hp_next;
            if (hist_found) hit <= 1'b1;
          end
          idx <= idx_end ? '0 : idx + TAG_IDX_W'(1);
        end
        S_EMIT: begin
          if (out_free) begin
            idx <= idx + TAG_IDX_W'(1);
            if (idx_end && hit) phase <= PH_HUNT;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_single || load_emit) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_single) begin
      o_byte   <= '0;
      o_pvalid <= 1'b0;
      o_last   <= 1'b1;
      if (func_q == FUNC_RESET) begin
        o_status <= ST_RESET;
      end else if (phase == PH_HUNT) begin
        o_status <= (cmp_hit && mc_inc == len_sel) ? ST_START : ST_NO_START;
      end else if (phase == PH_BODY) begin
        o_status <= (mc_inc == len_sel) ? ST_END : ST_IN_BODY;
      end else begin
        o_status <= ST_COMPLETE;
      end
    end else if (load_emit) begin
      o_status <= hit ? ST_HIST : ST_IN_BODY;
      o_byte   <= cur_char;
      o_pvalid <= 1'b1;
      o_last   <= idx_end;
    end
  end

  // checks
  a_payload_status: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.payload_valid |->
      out_ch.status == ST_IN_BODY || out_ch.status == ST_HIST)
    else $error("payload carried with a non-body status");

  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state == S_EVAL)
    else $error("accepted request not evaluated");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN || state == S_EMIT |-> idx <= cnt)
    else $error("flush index past flush length");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    load_emit && idx_end |=> state == S_IDLE && out_ch.valid && out_ch.last)
    else $error("flush end did not return to idle");

endmodule
